// ===== hw/rtl/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// aes_pkg
// AES-128 tables, round functions and shared types.
// ----------------------------------------------------------------------------
`default_nettype none
package aes_pkg;

  typedef enum logic [2:0] {
    ST_IDLE, ST_KEXP, ST_LOAD, ST_RUN, ST_OUT
  } state_t;

  localparam logic [2:0] REG_KEY_HI = 3'd0;
  localparam logic [2:0] REG_KEY_LO = 3'd1;
  localparam logic [2:0] REG_IV_HI  = 3'd2;
  localparam logic [2:0] REG_IV_LO  = 3'd3;
  localparam logic [2:0] REG_MODE   = 3'd4;

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
 8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
 8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
 8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
 8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
 8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
 8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
 8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
 8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
 8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
 8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
 8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
 8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
 8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
 8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
 8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
 8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    sbox = t[a];
  endfunction

  function automatic logic [7:0] sbox_inv(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
 8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
 8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
 8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
 8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
 8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
 8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
 8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
 8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
 8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
 8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
 8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
 8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
 8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
 8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
 8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
 8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    sbox_inv = t[a];
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] i);
    case (i)
      4'd0: rcon = 8'h01;
      4'd1: rcon = 8'h02;
      4'd2: rcon = 8'h04;
      4'd3: rcon = 8'h08;
      4'd4: rcon = 8'h10;
      4'd5: rcon = 8'h20;
      4'd6: rcon = 8'h40;
      4'd7: rcon = 8'h80;
      4'd8: rcon = 8'h1b;
      default: rcon = 8'h36;
    endcase
  endfunction

  // byte i of a block sits at bits 127-8i
  function automatic logic [7:0] byt(input logic [127:0] s, input int i);
    byt = s[127-8*i -: 8];
  endfunction

  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[127-8*(c*4+r) -: 8] = sbox(byt(s, ((c + r) & 3) * 4 + r));
    sub_shift = t;
  endfunction

  function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[127-8*(((c + r) & 3) * 4 + r) -: 8] = sbox_inv(byt(s, c*4+r));
    inv_sub_shift = t;
  endfunction

  function automatic logic [127:0] mix(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = byt(s, c*4); a1 = byt(s, c*4+1); a2 = byt(s, c*4+2); a3 = byt(s, c*4+3);
      t[127-8*(c*4)   -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
      t[127-8*(c*4+1) -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
      t[127-8*(c*4+2) -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
      t[127-8*(c*4+3) -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
    end
    mix = t;
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a [4];
    logic [7:0] x2, x4, x8;
    logic [7:0] m [4][4];
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        a[k] = byt(s, c*4+k);
        x2 = xt(a[k]); x4 = xt(x2); x8 = xt(x4);
        m[k][0] = x8 ^ x4 ^ x2;     // 0e
        m[k][1] = x8 ^ x2 ^ a[k];   // 0b
        m[k][2] = x8 ^ x4 ^ a[k];   // 0d
        m[k][3] = x8 ^ a[k];        // 09
      end
      for (int r = 0; r < 4; r++)
        t[127-8*(c*4+r) -: 8] = m[0][(0-r)&3] ^ m[1][(1-r)&3] ^ m[2][(2-r)&3]
                              ^ m[3][(3-r)&3];
    end
    inv_mix = t;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/aes128_cbc_block_cipher_unit.sv =====
// ----------------------------------------------------------------------------
// aes128_cbc_block_cipher_unit
// AES-128 CBC encrypt/decrypt with PKCS#7 pad and pad check.
// ----------------------------------------------------------------------------
// Each accepted word passes LOAD, RUN (10 rounds and a spare step) and the
// output register in OUT. The round loop does one round per cycle, with its
// round key read from the key RAM in the step before. A new word is accepted
// only in IDLE, once OUT has handed on the previous result.
// An encrypt last word with 16 bytes runs the loop twice for the pad word.
// Reset: key expansion from the zero key; input stalled until it completes.
`default_nettype none
module aes128_cbc_block_cipher_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] data_hi,
  input  wire logic [63:0] data_lo,
  input  wire logic        first_block,
  input  wire logic        last_block,
  input  wire logic [4:0]  byte_count,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_hi,
  output logic [63:0]      out_lo,
  output logic             out_last,
  output logic [4:0]       out_bytes,
  output logic             pad_error
);

  // Config registers
  logic [63:0] key_hi, key_lo, iv_hi, iv_lo;
  logic        decrypt_mode;
  logic        wr;
  logic [2:0]  ridx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign ridx   = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      key_hi <= '0; key_lo <= '0; iv_hi <= '0; iv_lo <= '0; decrypt_mode <= 1'b0;
    end else if (wr) begin
      unique case (ridx)
        aes_pkg::REG_KEY_HI: key_hi <= pwdata;
        aes_pkg::REG_KEY_LO: key_lo <= pwdata;
        aes_pkg::REG_IV_HI:  iv_hi <= pwdata;
        aes_pkg::REG_IV_LO:  iv_lo <= pwdata;
        aes_pkg::REG_MODE:   decrypt_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      aes_pkg::REG_KEY_HI: prdata = key_hi;
      aes_pkg::REG_KEY_LO: prdata = key_lo;
      aes_pkg::REG_IV_HI:  prdata = iv_hi;
      aes_pkg::REG_IV_LO:  prdata = iv_lo;
      aes_pkg::REG_MODE:   prdata = {63'd0, decrypt_mode};
      default:             prdata = '0;
    endcase
  end

  // Round key RAM: 11 entries of 128 bits, one per round
  logic [127:0] rk_mem [11];
  logic [127:0] rk_q;
  logic [3:0]   rk_raddr;
  logic         rk_we;
  logic [3:0]   rk_waddr;
  logic [127:0] rk_wdata;

  always_ff @(posedge clk) begin
    if (rk_we) rk_mem[rk_waddr] <= rk_wdata;
    rk_q <= rk_mem[rk_raddr];
  end

  aes_pkg::state_t state, state_next;
  logic [3:0]   cnt;       // key step or round number
  logic         key_dirty;
  logic [127:0] kreg;      // key expansion working word
  logic [127:0] st;        // cipher state
  logic [127:0] chain;
  logic [127:0] inblk;     // ciphertext word kept for decrypt chaining
  logic         dec, lst, pad2;
  logic [4:0]   nb;
  logic [127:0] res;
  logic         res_last, res_err;
  logic [4:0]   res_bytes;
  logic         pad_more;  // full encrypt last word still owes its pad word

  assign pad_more = !dec && lst && nb == 5'd16 && !pad2;

  // key expansion step
  logic [31:0] kt, kw0, kw1, kw2, kw3;
  always_comb begin
    kt = {aes_pkg::sbox(kreg[23:16]) ^ aes_pkg::rcon(cnt - 4'd1),
          aes_pkg::sbox(kreg[15:8]), aes_pkg::sbox(kreg[7:0]),
          aes_pkg::sbox(kreg[31:24])};
    kw0 = kreg[127:96] ^ kt;
    kw1 = kreg[95:64] ^ kw0;
    kw2 = kreg[63:32] ^ kw1;
    kw3 = kreg[31:0] ^ kw2;
  end

  wire acc = in_valid && !in_stall;

  // padded encrypt input
  logic [127:0] padded;
  logic [4:0]   nclip;
  always_comb begin
    nclip  = (byte_count > 5'd16) ? 5'd16 : byte_count;
    padded = {data_hi, data_lo};
    if (last_block && nclip < 5'd16)
      for (int i = 0; i < 16; i++)
        if (5'(i) >= nclip) padded[127-8*i -: 8] = 8'(5'd16 - nclip);
  end

  // decrypt pad check on final plaintext
  logic [127:0] dplain;
  logic [7:0]   pv;
  logic         bad;
  always_comb begin
    dplain = aes_pkg::inv_sub_shift(st) ^ rk_q ^ chain;
    pv     = dplain[7:0];
    bad    = (pv == 8'd0) || (pv > 8'd16);
    for (int i = 0; i < 16; i++)
      if (8'(i) < pv && dplain[8*i +: 8] != pv) bad = 1'b1;
  end

  wire [127:0] enc_last = aes_pkg::sub_shift(st) ^ rk_q;
  wire         ks_wr    = wr && (ridx == aes_pkg::REG_KEY_HI || ridx == aes_pkg::REG_KEY_LO);

  always_comb begin
    state_next = state;
    unique case (state)
      aes_pkg::ST_IDLE: if (key_dirty) state_next = aes_pkg::ST_KEXP;
                        else if (acc) state_next = aes_pkg::ST_LOAD;
      aes_pkg::ST_KEXP: if (cnt == 4'd10) state_next = aes_pkg::ST_IDLE;
      aes_pkg::ST_LOAD: state_next = aes_pkg::ST_RUN;
      aes_pkg::ST_RUN:  if (cnt == 4'd10) state_next = aes_pkg::ST_OUT;
      aes_pkg::ST_OUT:  if (!out_valid || !out_stall)
                          state_next = pad_more ? aes_pkg::ST_LOAD : aes_pkg::ST_IDLE;
      default: state_next = aes_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = !(state == aes_pkg::ST_IDLE && !key_dirty);
    rk_we    = (state == aes_pkg::ST_KEXP);
    rk_waddr = cnt;
    rk_wdata = (cnt == 4'd0) ? {key_hi, key_lo} : {kw0, kw1, kw2, kw3};
    // read one ahead: accept reads round 0/10, LOAD reads round 1/9,
    // RUN step cnt reads the round used at step cnt+1
    if (state == aes_pkg::ST_IDLE && in_valid && !key_dirty)
      rk_raddr = decrypt_mode ? 4'd10 : 4'd0;
    else if (state == aes_pkg::ST_LOAD)
      rk_raddr = dec ? 4'd9 : 4'd1;
    else if (state == aes_pkg::ST_RUN && cnt < 4'd9)
      rk_raddr = dec ? 4'(4'd8 - cnt) : 4'(cnt + 4'd2);
    else
      rk_raddr = dec ? 4'd10 : 4'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aes_pkg::ST_IDLE; key_dirty <= 1'b1; cnt <= '0; out_valid <= 1'b0;
      chain <= '0; pad2 <= 1'b0;
    end else begin
      state <= state_next;
      if (ks_wr) key_dirty <= 1'b1;
      else if (state == aes_pkg::ST_IDLE) key_dirty <= 1'b0;
      if (state == aes_pkg::ST_OUT && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        aes_pkg::ST_IDLE: begin
          cnt <= '0;
          if (acc) begin
            dec <= decrypt_mode; lst <= last_block; nb <= nclip; pad2 <= 1'b0;
            inblk <= {data_hi, data_lo};
            if (first_block) chain <= {iv_hi, iv_lo};
            st <= decrypt_mode ? {data_hi, data_lo} : padded;
          end
        end
        aes_pkg::ST_KEXP: begin
          kreg <= rk_wdata;
          cnt  <= cnt + 4'd1;
        end
        aes_pkg::ST_LOAD: begin
          st  <= dec ? (st ^ rk_q) : (st ^ chain ^ rk_q);
          cnt <= '0;
        end
        aes_pkg::ST_RUN: begin
          cnt <= cnt + 4'd1;
          if (cnt != 4'd9 && cnt != 4'd10) begin
            if (dec) st <= aes_pkg::inv_mix(aes_pkg::inv_sub_shift(st) ^ rk_q);
            else     st <= aes_pkg::mix(aes_pkg::sub_shift(st)) ^ rk_q;
          end
          if (cnt == 4'd9) begin
            if (dec) begin
              res <= dplain; chain <= inblk;
              res_last <= lst; res_err <= lst && bad;
              res_bytes <= (!lst) ? 5'd16 : (bad ? 5'd0 : 5'(5'd16 - pv[4:0]));
            end else begin
              res <= enc_last; chain <= enc_last;
              res_last <= lst && (nb < 5'd16); res_err <= 1'b0; res_bytes <= 5'd16;
            end
          end
        end
        aes_pkg::ST_OUT: begin
          if (!out_valid || !out_stall) begin
            {out_hi, out_lo} <= res;
            out_last <= res_last; out_bytes <= res_bytes; pad_error <= res_err;
            // full last word: queue the all-0x10 pad word
            pad2 <= pad_more;
            if (pad_more) begin
              st <= {16{8'h10}}; lst <= 1'b1; nb <= 5'd0;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/aes_checker.sv =====
// ----------------------------------------------------------------------------
// aes_checker
// Port-level checks for the cipher unit.
// ----------------------------------------------------------------------------
`default_nettype none
module aes_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [4:0] out_bytes,
  input wire logic       out_last,
  input wire logic       pad_error,
  input wire logic       pready
);
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && pad_error |-> out_last && out_bytes == 5'd0) else $error("pad err");
  a_bytes: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> out_bytes == 5'd16) else $error("bytes");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("hold");
  a_ready: assert property (@(posedge clk) pready) else $error("pready");
endmodule

bind aes128_cbc_block_cipher_unit aes_checker u_chk (.*);
`default_nettype wire
